[hdl/zupt_pkg.sv]
// Shared constants, types and helper functions of the stationary detector.
package zupt_pkg;

  // Default window depth in samples
  localparam int unsigned ZUPT_WINDOW = 64;

  // Field widths
  localparam int unsigned SMP_W   = 16;  // accel / yaw sample
  localparam int unsigned LIM_W   = 15;  // limit registers
  localparam int unsigned SPD_W   = 16;  // ground speed
  localparam int unsigned SAT_W   = 8;   // satellite count
  localparam int unsigned DWELL_W = 16;  // dwell time
  localparam int unsigned TS_W    = 32;  // millisecond timestamp
  localparam int unsigned SQ_W    = 31;  // square of a 16-bit sample magnitude
  localparam int unsigned RING_W  = 3 * SMP_W;

  // Register port
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned IDX_W  = ADDR_W - 2;

  // Register indices
  localparam logic [IDX_W-1:0] REG_SPEED_LIMIT = 3'd0;
  localparam logic [IDX_W-1:0] REG_YAW_LIMIT   = 3'd1;
  localparam logic [IDX_W-1:0] REG_MAG_LIMIT   = 3'd2;
  localparam logic [IDX_W-1:0] REG_ACC_STD     = 3'd3;
  localparam logic [IDX_W-1:0] REG_YAW_STD     = 3'd4;
  localparam logic [IDX_W-1:0] REG_DWELL       = 3'd5;
  localparam logic [IDX_W-1:0] REG_MIN_SATS    = 3'd6;

  // Register reset values
  localparam logic [SPD_W-1:0]   RST_SPEED_LIMIT = 16'd100;
  localparam logic [LIM_W-1:0]   RST_YAW_LIMIT   = 15'd40;
  localparam logic [LIM_W-1:0]   RST_MAG_LIMIT   = 15'd200;
  localparam logic [LIM_W-1:0]   RST_ACC_STD     = 15'd50;
  localparam logic [LIM_W-1:0]   RST_YAW_STD     = 15'd20;
  localparam logic [DWELL_W-1:0] RST_DWELL       = 16'd500;
  localparam logic [SAT_W-1:0]   RST_MIN_SATS    = 8'd20;

  // Verdict of the variance unit for one channel
  typedef struct packed {
    logic vld;
    logic ok;
  } var_res_t;

  // Magnitude of a two's complement sample, one bit wider
  function automatic logic [SMP_W:0] mag16(input logic [SMP_W-1:0] v);
    logic [SMP_W:0] e;
    e = {v[SMP_W-1], v};
    return v[SMP_W-1] ? (~e + 1'b1) : e;
  endfunction

endpackage

[hdl/zupt_sample_if.sv]
// Input channel: one bias-corrected IMU sample with GPS side data per word.
interface zupt_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] yaw_rate;
  logic        [15:0] ground_speed;
  logic               gps_valid;
  logic        [7:0]  sat_count;
  logic        [31:0] now_ms;

  modport source (
    output valid, accel_x, accel_y, yaw_rate, ground_speed, gps_valid, sat_count, now_ms,
    input  ready
  );
  modport sink (
    input  valid, accel_x, accel_y, yaw_rate, ground_speed, gps_valid, sat_count, now_ms,
    output ready
  );
endinterface

[hdl/zupt_result_if.sv]
// Output channel: one stationary verdict per word.
interface zupt_result_if;
  logic valid;
  logic ready;
  logic stationary;
  logic warming_up;

  modport source (
    output valid, stationary, warming_up,
    input  ready
  );
  modport sink (
    input  valid, stationary, warming_up,
    output ready
  );
endinterface

[hdl/zupt_ring_ram.sv]
// Sample window memory: one row holds ax, ay and yaw of one sample, registered read.
module zupt_ring_ram #(
  parameter  int unsigned WINDOW = zupt_pkg::ZUPT_WINDOW,
  localparam int unsigned SLOT_W = $clog2(WINDOW)
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [SLOT_W-1:0]         waddr_i,
  input  logic [zupt_pkg::RING_W-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [SLOT_W-1:0]         raddr_i,
  output logic [zupt_pkg::RING_W-1:0] rdata_o
);
  import zupt_pkg::*;

  logic [RING_W-1:0] mem [WINDOW];
  logic [RING_W-1:0] rdata_q;

  // single write port, single read port, read data registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/zupt_var_unit.sv]
// Three-stage variance test: n*sumsq - sum^2 <= (limit*n)^2, one channel per cycle.
module zupt_var_unit #(
  parameter  int unsigned WINDOW  = zupt_pkg::ZUPT_WINDOW,
  localparam int unsigned N_W     = $clog2(WINDOW + 1),
  localparam int unsigned SUM_W   = zupt_pkg::SMP_W + $clog2(WINDOW),
  localparam int unsigned SUMSQ_W = zupt_pkg::SQ_W + $clog2(WINDOW)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       vld_i,
  input  logic [N_W-1:0]             n_i,
  input  logic [SUM_W-1:0]           sum_i,
  input  logic [SUMSQ_W-1:0]         sumsq_i,
  input  logic [zupt_pkg::LIM_W-1:0] limit_i,
  output zupt_pkg::var_res_t         res_o
);
  import zupt_pkg::*;

  localparam int unsigned A_W    = N_W + SUMSQ_W;
  localparam int unsigned B_W    = 2 * SUM_W;
  localparam int unsigned LN_W   = LIM_W + N_W;
  localparam int unsigned C_W    = 2 * LN_W;
  localparam int unsigned AB_W   = (A_W > B_W) ? A_W : B_W;
  localparam int unsigned PROD_W = (AB_W > C_W) ? AB_W : C_W;

  logic [SUM_W-1:0]  sum_mag;
  logic [A_W-1:0]    a_full;
  logic [B_W-1:0]    b_full;
  logic [LN_W-1:0]   ln_full;
  logic [C_W-1:0]    c_full;

  logic              v1_q, v2_q;
  logic [A_W-1:0]    a1_q;
  logic [B_W-1:0]    b1_q;
  logic [LN_W-1:0]   ln1_q;
  logic [PROD_W-1:0] diff2_q;
  logic [C_W-1:0]    c2_q;
  logic              res_vld_q;
  logic              res_ok_q;

  // stage 1: n*sumsq, |sum|^2 and limit*n
  assign sum_mag = sum_i[SUM_W-1] ? (~sum_i + 1'b1) : sum_i;
  assign a_full  = n_i * sumsq_i;
  assign b_full  = sum_mag * sum_mag;
  assign ln_full = limit_i * n_i;

  // stage 2: (limit*n)^2
  assign c_full = ln1_q * ln1_q;

  // valid pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      v1_q      <= vld_i;
      v2_q      <= v1_q;
      res_vld_q <= v2_q;
    end
  end

  // data pipe; n*sumsq never falls below sum^2, so the difference is exact
  always_ff @(posedge clk_i) begin
    a1_q     <= a_full;
    b1_q     <= b_full;
    ln1_q    <= ln_full;
    diff2_q  <= PROD_W'(a1_q) - PROD_W'(b1_q);
    c2_q     <= c_full;
    res_ok_q <= (diff2_q <= PROD_W'(c2_q));
  end

  assign res_o = '{vld: res_vld_q, ok: res_ok_q};

endmodule

[hdl/zupt_stationary_detector.sv]
// Stationary (zero-velocity) detector: window statistics, still tests, dwell timing.
//
// Use: samples arrive on sample_i (valid/ready), one verdict per sample leaves
// on result_o (valid/ready). Limits, dwell time and satellite threshold sit in
// an APB register block; the user must write them only while no sample is in
// flight; the block itself does not enforce this. Each accepted sample is
// read-modify-written into the window memory: the row at the write slot is
// read on accept, the new sample is written back in the next cycle and the
// running sums and sums of squares are updated. A verdict is registered after
// the seven steps of the shared squarer and the three-stage variance pipeline
// fed with three channels; it is skipped while the window holds fewer than
// WINDOW/2 samples. No new sample is taken until the last verdict is registered.
// Reset clears the sums, slot, fill flag, dwell timing and registers (limits
// back to their defaults); the window memory itself is not cleared, since
// its rows read back are used only once the window has filled.
// A stalled receiver holds the verdict in the output register; the next
// sample is still accepted, and its verdict waits until the register frees.
module zupt_stationary_detector #(
  parameter  int unsigned WINDOW = zupt_pkg::ZUPT_WINDOW
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  zupt_sample_if.sink                 sample_i,
  zupt_result_if.source               result_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [zupt_pkg::ADDR_W-1:0] paddr,
  input  logic [zupt_pkg::DATA_W-1:0] pwdata,
  output logic [zupt_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import zupt_pkg::*;

  localparam int unsigned SLOT_W  = $clog2(WINDOW);
  localparam int unsigned N_W     = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W   = SMP_W + $clog2(WINDOW);
  localparam int unsigned SUMSQ_W = SQ_W + $clog2(WINDOW);
  localparam int unsigned EXT_W   = SUM_W - SMP_W;

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SQ     = 3'd1;
  localparam logic [2:0] ST_SLOT   = 3'd2;
  localparam logic [2:0] ST_VAR    = 3'd3;
  localparam logic [2:0] ST_WAIT   = 3'd4;
  localparam logic [2:0] ST_DECIDE = 3'd5;

  // squarer steps
  localparam logic [2:0] SQ_AX_NEW  = 3'd0;
  localparam logic [2:0] SQ_AY_NEW  = 3'd1;
  localparam logic [2:0] SQ_YAW_NEW = 3'd2;
  localparam logic [2:0] SQ_AX_OLD  = 3'd3;
  localparam logic [2:0] SQ_AY_OLD  = 3'd4;
  localparam logic [2:0] SQ_YAW_OLD = 3'd5;
  localparam logic [2:0] SQ_MAG_LIM = 3'd6;

  // variance channels
  localparam logic [1:0] CH_AX  = 2'd0;
  localparam logic [1:0] CH_AY  = 2'd1;
  localparam logic [1:0] CH_YAW = 2'd2;

  // registers
  logic [SPD_W-1:0]   speed_lim_q;
  logic [LIM_W-1:0]   yaw_lim_q, mag_lim_q, acc_std_q, yaw_std_q;
  logic [DWELL_W-1:0] dwell_q;
  logic [SAT_W-1:0]   min_sats_q;

  // control state
  logic [2:0]        state_q, state_d;
  logic [2:0]        step_q;
  logic [SLOT_W-1:0] slot_q, slot_nxt;
  logic              full_q, full_nxt;
  logic [N_W-1:0]    n_q, n_nxt;
  logic              warm_q, warm_nxt;
  logic              timing_q, flag_q;
  logic [TS_W-1:0]   since_q;
  logic [1:0]        var_cnt_q, done_cnt_q;
  logic              var_ok_q;
  logic              out_vld_q;

  // running statistics
  logic [SUM_W-1:0]   ax_tot_q, ay_tot_q, yaw_tot_q;
  logic [SUMSQ_W-1:0] ax_sq_q, ay_sq_q, yaw_sq_q;

  // sample and datapath registers
  logic [SMP_W-1:0] ax_q, ay_q, yaw_q;
  logic [SPD_W-1:0] gspeed_q;
  logic             gvalid_q;
  logic [SAT_W-1:0] sats_q;
  logic [TS_W-1:0]  now_q;
  logic [SQ_W-1:0]  sq_q, lim2_q;
  logic [2:0]       sq_tag_q;
  logic             sq_vld_q;
  logic [SQ_W:0]    mag_q;
  logic             out_stat_q, out_warm_q;

  // combinational
  logic                 accept, load;
  logic                 cfg_wr;
  logic [IDX_W-1:0]     cfg_idx;
  logic [RING_W-1:0]    ring_rd, ring_wr;
  logic [SMP_W-1:0]     old_ax, old_ay, old_yaw;
  logic [SMP_W:0]       sq_op;
  logic [2*SMP_W+1:0]   sq_prod;
  logic [SUM_W-1:0]     ax_new_x, ay_new_x, yaw_new_x, ax_old_x, ay_old_x, yaw_old_x;
  logic                 var_vld;
  logic [SUM_W-1:0]     var_sum;
  logic [SUMSQ_W-1:0]   var_sumsq;
  logic [LIM_W-1:0]     var_lim;
  var_res_t             var_res;
  logic                 yaw_ok, mag_ok, gps_ok, still;
  logic [TS_W-1:0]      since_use;
  logic                 dwell_met;

  // ---------------------------------------------------------------- APB
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[ADDR_W-1:2];

  always_comb begin
    case (cfg_idx)
      REG_SPEED_LIMIT: prdata = DATA_W'(speed_lim_q);
      REG_YAW_LIMIT:   prdata = DATA_W'(yaw_lim_q);
      REG_MAG_LIMIT:   prdata = DATA_W'(mag_lim_q);
      REG_ACC_STD:     prdata = DATA_W'(acc_std_q);
      REG_YAW_STD:     prdata = DATA_W'(yaw_std_q);
      REG_DWELL:       prdata = DATA_W'(dwell_q);
      REG_MIN_SATS:    prdata = DATA_W'(min_sats_q);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_lim_q <= RST_SPEED_LIMIT;
      yaw_lim_q   <= RST_YAW_LIMIT;
      mag_lim_q   <= RST_MAG_LIMIT;
      acc_std_q   <= RST_ACC_STD;
      yaw_std_q   <= RST_YAW_STD;
      dwell_q     <= RST_DWELL;
      min_sats_q  <= RST_MIN_SATS;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SPEED_LIMIT: speed_lim_q <= pwdata[SPD_W-1:0];
        REG_YAW_LIMIT:   yaw_lim_q   <= pwdata[LIM_W-1:0];
        REG_MAG_LIMIT:   mag_lim_q   <= pwdata[LIM_W-1:0];
        REG_ACC_STD:     acc_std_q   <= pwdata[LIM_W-1:0];
        REG_YAW_STD:     yaw_std_q   <= pwdata[LIM_W-1:0];
        REG_DWELL:       dwell_q     <= pwdata[DWELL_W-1:0];
        REG_MIN_SATS:    min_sats_q  <= pwdata[SAT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- handshake
  assign sample_i.ready      = (state_q == ST_IDLE);
  assign accept              = sample_i.valid && sample_i.ready;
  assign load                = (state_q == ST_DECIDE) && (!out_vld_q || result_o.ready);
  assign result_o.valid      = out_vld_q;
  assign result_o.stationary = out_stat_q;
  assign result_o.warming_up = out_warm_q;

  // ---------------------------------------------------------------- window memory
  // row read at accept, written back at the first squarer step: no overlap
  assign ring_wr = {ax_q, ay_q, yaw_q};

  zupt_ring_ram #(.WINDOW(WINDOW)) u_ram (
    .clk_i   (clk_i),
    .we_i    ((state_q == ST_SQ) && (step_q == SQ_AX_NEW)),
    .waddr_i (slot_q),
    .wdata_i (ring_wr),
    .re_i    (accept),
    .raddr_i (slot_q),
    .rdata_o (ring_rd)
  );

  assign old_ax  = ring_rd[3*SMP_W-1:2*SMP_W];
  assign old_ay  = ring_rd[2*SMP_W-1:SMP_W];
  assign old_yaw = ring_rd[SMP_W-1:0];

  assign ax_new_x  = {{EXT_W{ax_q[SMP_W-1]}}, ax_q};
  assign ay_new_x  = {{EXT_W{ay_q[SMP_W-1]}}, ay_q};
  assign yaw_new_x = {{EXT_W{yaw_q[SMP_W-1]}}, yaw_q};
  assign ax_old_x  = {{EXT_W{old_ax[SMP_W-1]}}, old_ax};
  assign ay_old_x  = {{EXT_W{old_ay[SMP_W-1]}}, old_ay};
  assign yaw_old_x = {{EXT_W{old_yaw[SMP_W-1]}}, old_yaw};

  // ---------------------------------------------------------------- shared squarer
  always_comb begin
    case (step_q)
      SQ_AX_NEW:  sq_op = mag16(ax_q);
      SQ_AY_NEW:  sq_op = mag16(ay_q);
      SQ_YAW_NEW: sq_op = mag16(yaw_q);
      SQ_AX_OLD:  sq_op = mag16(old_ax);
      SQ_AY_OLD:  sq_op = mag16(old_ay);
      SQ_YAW_OLD: sq_op = mag16(old_yaw);
      SQ_MAG_LIM: sq_op = {2'b00, mag_lim_q};
      default:    sq_op = '0;
    endcase
  end

  assign sq_prod = sq_op * sq_op;

  // ---------------------------------------------------------------- slot advance
  assign slot_nxt = (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
  assign full_nxt = full_q || (slot_q == SLOT_W'(WINDOW - 1));
  assign n_nxt    = full_nxt ? N_W'(WINDOW) : N_W'(slot_nxt);
  assign warm_nxt = n_nxt < N_W'(WINDOW / 2);

  // ---------------------------------------------------------------- variance feed
  assign var_vld = (state_q == ST_VAR);

  always_comb begin
    case (var_cnt_q)
      CH_AX: begin
        var_sum   = ax_tot_q;
        var_sumsq = ax_sq_q;
        var_lim   = acc_std_q;
      end
      CH_AY: begin
        var_sum   = ay_tot_q;
        var_sumsq = ay_sq_q;
        var_lim   = acc_std_q;
      end
      CH_YAW: begin
        var_sum   = yaw_tot_q;
        var_sumsq = yaw_sq_q;
        var_lim   = yaw_std_q;
      end
      default: begin
        var_sum   = '0;
        var_sumsq = '0;
        var_lim   = '0;
      end
    endcase
  end

  zupt_var_unit #(.WINDOW(WINDOW)) u_var (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (var_vld),
    .n_i     (n_q),
    .sum_i   (var_sum),
    .sumsq_i (var_sumsq),
    .limit_i (var_lim),
    .res_o   (var_res)
  );

  // ---------------------------------------------------------------- still tests and dwell
  assign yaw_ok    = mag16(yaw_q) <= {2'b00, yaw_lim_q};
  assign mag_ok    = mag_q <= {1'b0, lim2_q};
  assign gps_ok    = !gvalid_q || (gspeed_q <= speed_lim_q);
  assign still     = yaw_ok && mag_ok && var_ok_q && ((sats_q <= min_sats_q) || gps_ok);
  assign since_use = timing_q ? since_q : now_q;
  assign dwell_met = (now_q - since_use) >= TS_W'(dwell_q);

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (accept) state_d = ST_SQ;
      ST_SQ:     if (step_q == SQ_MAG_LIM) state_d = ST_SLOT;
      ST_SLOT:   state_d = warm_nxt ? ST_DECIDE : ST_VAR;
      ST_VAR:    if (var_cnt_q == CH_YAW) state_d = ST_WAIT;
      ST_WAIT:   if (var_res.vld && (done_cnt_q == CH_YAW)) state_d = ST_DECIDE;
      ST_DECIDE: if (load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      step_q     <= SQ_AX_NEW;
      slot_q     <= '0;
      full_q     <= 1'b0;
      n_q        <= '0;
      warm_q     <= 1'b0;
      timing_q   <= 1'b0;
      since_q    <= '0;
      flag_q     <= 1'b0;
      var_cnt_q  <= CH_AX;
      done_cnt_q <= CH_AX;
      var_ok_q   <= 1'b1;
      sq_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      ax_tot_q   <= '0;
      ay_tot_q   <= '0;
      yaw_tot_q  <= '0;
      ax_sq_q    <= '0;
      ay_sq_q    <= '0;
      yaw_sq_q   <= '0;
    end else begin
      state_q  <= state_d;
      sq_vld_q <= (state_q == ST_SQ);

      // squarer step counter
      if (accept) begin
        step_q <= SQ_AX_NEW;
      end else if (state_q == ST_SQ) begin
        step_q <= step_q + 3'd1;
      end

      // sums: add the new sample, drop the one it replaces once full
      if ((state_q == ST_SQ) && (step_q == SQ_AX_NEW)) begin
        ax_tot_q  <= ax_tot_q + ax_new_x - (full_q ? ax_old_x : '0);
        ay_tot_q  <= ay_tot_q + ay_new_x - (full_q ? ay_old_x : '0);
        yaw_tot_q <= yaw_tot_q + yaw_new_x - (full_q ? yaw_old_x : '0);
      end

      // sums of squares, one registered square per cycle
      if (sq_vld_q) begin
        case (sq_tag_q)
          SQ_AX_NEW:  ax_sq_q  <= ax_sq_q + SUMSQ_W'(sq_q);
          SQ_AY_NEW:  ay_sq_q  <= ay_sq_q + SUMSQ_W'(sq_q);
          SQ_YAW_NEW: yaw_sq_q <= yaw_sq_q + SUMSQ_W'(sq_q);
          SQ_AX_OLD:  if (full_q) ax_sq_q  <= ax_sq_q - SUMSQ_W'(sq_q);
          SQ_AY_OLD:  if (full_q) ay_sq_q  <= ay_sq_q - SUMSQ_W'(sq_q);
          SQ_YAW_OLD: if (full_q) yaw_sq_q <= yaw_sq_q - SUMSQ_W'(sq_q);
          default: ;
        endcase
      end

      // advance the write slot and sample count
      if (state_q == ST_SLOT) begin
        slot_q     <= slot_nxt;
        full_q     <= full_nxt;
        n_q        <= n_nxt;
        warm_q     <= warm_nxt;
        var_cnt_q  <= CH_AX;
        done_cnt_q <= CH_AX;
        var_ok_q   <= 1'b1;
      end

      // feed the three channels, gather their verdicts
      if (state_q == ST_VAR) begin
        var_cnt_q <= var_cnt_q + 2'd1;
      end
      if (var_res.vld) begin
        done_cnt_q <= done_cnt_q + 2'd1;
        var_ok_q   <= var_ok_q && var_res.ok;
      end

      // dwell bookkeeping at the verdict
      if (load) begin
        if (warm_q) begin
          timing_q <= 1'b0;
          since_q  <= '0;
          flag_q   <= 1'b1;
        end else if (still) begin
          timing_q <= 1'b1;
          since_q  <= since_use;
          if (dwell_met) begin
            flag_q <= 1'b1;
          end
        end else begin
          timing_q <= 1'b0;
          since_q  <= '0;
          flag_q   <= 1'b0;
        end
      end

      // output register
      if (load) begin
        out_vld_q <= 1'b1;
      end else if (result_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ax_q     <= sample_i.accel_x;
      ay_q     <= sample_i.accel_y;
      yaw_q    <= sample_i.yaw_rate;
      gspeed_q <= sample_i.ground_speed;
      gvalid_q <= sample_i.gps_valid;
      sats_q   <= sample_i.sat_count;
      now_q    <= sample_i.now_ms;
    end
    sq_q     <= sq_prod[SQ_W-1:0];
    sq_tag_q <= step_q;
    if (sq_vld_q) begin
      case (sq_tag_q)
        SQ_AX_NEW:  mag_q  <= {1'b0, sq_q};
        SQ_AY_NEW:  mag_q  <= mag_q + {1'b0, sq_q};
        SQ_MAG_LIM: lim2_q <= sq_q;
        default: ;
      endcase
    end
    if (load) begin
      out_warm_q <= warm_q;
      out_stat_q <= warm_q || (still && (dwell_met || flag_q));
    end
  end

endmodule

[hdl/zupt_checker.sv]
// Port-level checks of the stationary detector, bound to its top level.
module zupt_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic stationary_i,
  input logic warming_up_i
);

  // warm-up verdicts always report stationary
  a_warm_stationary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && warming_up_i |-> stationary_i)
    else $error("warming_up word without stationary");

  // one sample in flight: no accept in the cycle after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready right after an accepted word");

  // a stalled verdict stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result valid dropped while stalled");

  // a stalled verdict keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(stationary_i) && $stable(warming_up_i))
    else $error("result word changed while stalled");

endmodule

bind zupt_stationary_detector zupt_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (sample_i.valid),
  .in_ready_i   (sample_i.ready),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .stationary_i (result_o.stationary),
  .warming_up_i (result_o.warming_up)
);
